FILE: sv/hv_precharge_sequencer_assert.svh
// ----------------------------------------------------------------------------
// HV precharge sequencer assertion macros
// Concurrent assertion wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HV_PRECHARGE_SEQUENCER_ASSERT_SVH
`define HV_PRECHARGE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HVPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HVPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define HVPS_ASSERT_NOW(label, ante, cons, msg)
`define HVPS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: sv/hvps_pkg.sv
// ----------------------------------------------------------------------------
// HV precharge sequencer package
// Field widths, register indexes, phase encoding and contactor bit masks.
// ----------------------------------------------------------------------------
package hvps_pkg;

    // field widths
    localparam int MV_W     = 12;
    localparam int GAIN_W   = 24;
    localparam int VOLT_W   = 20;
    localparam int TICKS_W  = 16;
    localparam int RL_W     = 2;
    localparam int PHASE_W  = 3;
    localparam int DRV_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HV_THR       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAWDOWN     = 3'd4;

    // configuration reset values
    localparam logic [MV_W-1:0]    RST_ADC_OFFSET  = 12'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN        = 24'd65536;
    localparam logic [VOLT_W-1:0]  RST_CONNECT_THR = 20'd8192;
    localparam logic [VOLT_W-1:0]  RST_HV_THR      = 20'd15360;
    localparam logic [TICKS_W-1:0] RST_DRAWDOWN    = 16'd150;

    // runlevel request codes
    localparam logic [RL_W-1:0] RL_NO_HV     = 2'd0;
    localparam logic [RL_W-1:0] RL_PLEASE_HV = 2'd1;

    // phase codes as reported on the result channel
    localparam logic [PHASE_W-1:0] PC_IDLE          = 3'd0;
    localparam logic [PHASE_W-1:0] PC_PRECHARGING   = 3'd1;
    localparam logic [PHASE_W-1:0] PC_CONNECTED     = 3'd2;
    localparam logic [PHASE_W-1:0] PC_DISCONNECTING = 3'd3;
    localparam logic [PHASE_W-1:0] PC_FAULT         = 3'd4;

    // contactor drive bits
    localparam logic [DRV_W-1:0] DRV_NEG = 3'b001;
    localparam logic [DRV_W-1:0] DRV_POS = 3'b010;
    localparam logic [DRV_W-1:0] DRV_PRE = 3'b100;

    // sequencer state, one-hot
    typedef enum logic [4:0] {
        PH_IDLE          = 5'b00001,
        PH_PRECHARGING   = 5'b00010,
        PH_CONNECTED     = 5'b00100,
        PH_DISCONNECTING = 5'b01000,
        PH_FAULT         = 5'b10000
    } t_phase;

    // one-hot state to reported phase code
    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_IDLE:          code = PC_IDLE;
            PH_PRECHARGING:   code = PC_PRECHARGING;
            PH_CONNECTED:     code = PC_CONNECTED;
            PH_DISCONNECTING: code = PC_DISCONNECTING;
            default:          code = PC_FAULT;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/hvps_if.sv
// ----------------------------------------------------------------------------
// HV precharge sequencer channel interfaces
// Valid/ready channels for tick samples, results and register writes.
// ----------------------------------------------------------------------------

// tick sample channel
interface hvps_in_if;
    logic                          valid;
    logic                          ready;
    logic [hvps_pkg::MV_W-1:0]     calibrated_mv;
    logic                          supervisor_ok;
    logic [hvps_pkg::RL_W-1:0]     runlevel_request;

    modport source (output valid, calibrated_mv, supervisor_ok, runlevel_request,
                    input ready);
    modport sink   (input valid, calibrated_mv, supervisor_ok, runlevel_request,
                    output ready);
endinterface

// result channel
interface hvps_out_if;
    logic                          valid;
    logic                          ready;
    logic [hvps_pkg::PHASE_W-1:0]  phase;
    logic                          air_negative_closed;
    logic                          air_positive_closed;
    logic                          precharge_relay_closed;
    logic [hvps_pkg::VOLT_W-1:0]   bus_voltage_q8;
    logic                          reboot_allowed;

    modport source (output valid, phase, air_negative_closed, air_positive_closed,
                    precharge_relay_closed, bus_voltage_q8, reboot_allowed,
                    input ready);
    modport sink   (input valid, phase, air_negative_closed, air_positive_closed,
                    precharge_relay_closed, bus_voltage_q8, reboot_allowed,
                    output ready);
endinterface

// register write channel
interface hvps_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [hvps_pkg::CFG_IDX_W-1:0]    index;
    logic [hvps_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/hv_precharge_sequencer.sv
// ----------------------------------------------------------------------------
// HV precharge sequencer
// Converts the isoamp reading to Q8 bus volts and steps the contactor sequence.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one item per 1 ms tick (millivolt sample, supervisor flag,
//            requested runlevel).
//   o_out  : one result item per input item: phase, three contactor drives,
//            bus voltage in Q8 volts and the reboot-allowed flag.
//   i_cfg  : register writes (index 0..4), always ready; issue them only
//            while no item is in flight. Writes to other indexes are dropped.
// Pipeline: an accepted item passes the input register, the voltage register
//   and the result register, in that order.
// Throughput: one item per cycle unless o_out stalls. The sequencer state
//   updates as an item moves into the result register; the next item sees it.
// Stall: each stage holds while the stage after it is full and stalled;
//   i_in.ready drops only once all three stages are occupied.
// Reset: synchronous, active low. Empties the pipeline, sets phase idle,
//   opens all contactors, clears the phase timer and the edge detector, and
//   restores the register defaults.
// ----------------------------------------------------------------------------
`include "hv_precharge_sequencer_assert.svh"

module hv_precharge_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hvps_in_if.sink          i_in,
    hvps_out_if.source       o_out,
    hvps_cfg_if.sink         i_cfg
);

    localparam int PROD_W = hvps_pkg::MV_W + hvps_pkg::GAIN_W;

    // configuration registers
    logic [hvps_pkg::MV_W-1:0]    r_adc_offset;
    logic [hvps_pkg::GAIN_W-1:0]  r_gain;
    logic [hvps_pkg::VOLT_W-1:0]  r_connect_thr;
    logic [hvps_pkg::VOLT_W-1:0]  r_hv_thr;
    logic [hvps_pkg::TICKS_W-1:0] r_drawdown;

    // stage 1: input register
    logic                         r_s1_valid;
    logic [hvps_pkg::MV_W-1:0]    r_s1_mv;
    logic                         r_s1_sup;
    logic [hvps_pkg::RL_W-1:0]    r_s1_rl;

    // stage 2: voltage register
    logic                         r_s2_valid;
    logic [hvps_pkg::VOLT_W-1:0]  r_s2_volt;
    logic                         r_s2_sup;
    logic [hvps_pkg::RL_W-1:0]    r_s2_rl;

    // result register and sequencer state
    logic                         r_out_valid;
    logic [hvps_pkg::VOLT_W-1:0]  r_out_volt;
    hvps_pkg::t_phase             r_phase;
    hvps_pkg::t_phase             n_phase;
    logic [hvps_pkg::TICKS_W-1:0] r_ticks;
    logic [hvps_pkg::TICKS_W-1:0] n_ticks;
    logic                         r_please_prev;
    logic [hvps_pkg::DRV_W-1:0]   r_drive;
    logic [hvps_pkg::DRV_W-1:0]   n_drive;

    // handshake
    logic w_out_free;
    logic w_s2_ready;
    logic w_s1_ready;
    logic w_s1_adv;
    logic w_s2_adv;
    logic w_in_acc;

    // datapath
    logic [hvps_pkg::MV_W-1:0]    w_diff;
    logic [PROD_W-1:0]            w_prod;
    logic [PROD_W-9:0]            w_shifted;
    logic [hvps_pkg::VOLT_W-1:0]  w_volt;
    logic                         w_please;
    logic                         w_no_hv;
    logic                         w_hv;
    logic                         w_drawn;
    logic [hvps_pkg::TICKS_W-1:0] w_ticks_inc;

    // stage ready chain
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s2_ready = !r_s2_valid || w_out_free;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign w_s2_adv   = r_s2_valid && w_out_free;
    assign w_s1_adv   = r_s1_valid && w_s2_ready;
    assign w_in_acc   = i_in.valid && w_s1_ready;
    assign i_in.ready = w_s1_ready;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_offset  <= hvps_pkg::RST_ADC_OFFSET;
            r_gain        <= hvps_pkg::RST_GAIN;
            r_connect_thr <= hvps_pkg::RST_CONNECT_THR;
            r_hv_thr      <= hvps_pkg::RST_HV_THR;
            r_drawdown    <= hvps_pkg::RST_DRAWDOWN;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                hvps_pkg::CFG_ADC_OFFSET:  r_adc_offset  <= i_cfg.data[hvps_pkg::MV_W-1:0];
                hvps_pkg::CFG_GAIN:        r_gain        <= i_cfg.data[hvps_pkg::GAIN_W-1:0];
                hvps_pkg::CFG_CONNECT_THR: r_connect_thr <= i_cfg.data[hvps_pkg::VOLT_W-1:0];
                hvps_pkg::CFG_HV_THR:      r_hv_thr      <= i_cfg.data[hvps_pkg::VOLT_W-1:0];
                hvps_pkg::CFG_DRAWDOWN:    r_drawdown    <= i_cfg.data[hvps_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // offset removal, gain multiply, Q16 -> Q8 and saturation
    always_comb begin
        w_diff    = (i_rst_n && r_s1_mv > r_adc_offset) ? (r_s1_mv - r_adc_offset)
                                                        : '0;
        w_prod    = PROD_W'(w_diff) * PROD_W'(r_gain);
        w_shifted = w_prod[PROD_W-1:8];
        w_volt    = (|w_shifted[PROD_W-9:hvps_pkg::VOLT_W]) ? '1
                                                           : w_shifted[hvps_pkg::VOLT_W-1:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) r_s1_valid  <= i_in.valid;
            if (w_s2_ready) r_s2_valid  <= r_s1_valid;
            if (w_out_free) r_out_valid <= r_s2_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_mv  <= i_in.calibrated_mv;
            r_s1_sup <= i_in.supervisor_ok;
            r_s1_rl  <= i_in.runlevel_request;
        end
        if (w_s1_adv) begin
            r_s2_volt <= w_volt;
            r_s2_sup  <= r_s1_sup;
            r_s2_rl   <= r_s1_rl;
        end
        if (w_s2_adv) begin
            r_out_volt <= r_s2_volt;
        end
    end

    // sequencer next state
    always_comb begin
        w_please    = r_s2_sup && (r_s2_rl == hvps_pkg::RL_PLEASE_HV);
        w_no_hv     = r_s2_sup && (r_s2_rl == hvps_pkg::RL_NO_HV);
        w_hv        = r_s2_volt >= r_hv_thr;
        w_ticks_inc = (&r_ticks) ? r_ticks : r_ticks + 1'b1;
        w_drawn     = !w_hv || (w_ticks_inc > r_drawdown);
        n_phase     = r_phase;
        n_drive     = r_drive;
        case (r_phase)
            hvps_pkg::PH_IDLE: begin
                if (w_please && !r_please_prev) begin
                    n_drive = r_drive | hvps_pkg::DRV_NEG | hvps_pkg::DRV_PRE;
                    n_phase = hvps_pkg::PH_PRECHARGING;
                end else begin
                    n_drive = '0;
                end
            end
            hvps_pkg::PH_PRECHARGING: begin
                if (w_no_hv || !r_s2_sup) begin
                    n_phase = hvps_pkg::PH_DISCONNECTING;
                end else if (r_s2_volt >= r_connect_thr) begin
                    n_drive = r_drive | hvps_pkg::DRV_POS;
                    n_phase = hvps_pkg::PH_CONNECTED;
                end
            end
            hvps_pkg::PH_CONNECTED: begin
                if (w_no_hv || !r_s2_sup) n_phase = hvps_pkg::PH_DISCONNECTING;
            end
            hvps_pkg::PH_DISCONNECTING: begin
                if (w_drawn) begin
                    n_drive = '0;
                    n_phase = hvps_pkg::PH_IDLE;
                end
            end
            hvps_pkg::PH_FAULT: begin
                if (w_drawn) n_drive = '0;
            end
            default: n_phase = hvps_pkg::PH_FAULT;
        endcase
        // timer restarts on every phase change
        n_ticks = (n_phase != r_phase) ? '0 : w_ticks_inc;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= hvps_pkg::PH_IDLE;
            r_ticks       <= '0;
            r_please_prev <= 1'b0;
            r_drive       <= '0;
        end else if (w_s2_adv) begin
            r_phase       <= n_phase;
            r_ticks       <= n_ticks;
            r_please_prev <= w_please;
            r_drive       <= n_drive;
        end
    end

    // result fields
    assign o_out.valid                  = r_out_valid;
    assign o_out.phase                  = hvps_pkg::phase_code(r_phase);
    assign o_out.air_negative_closed    = |(r_drive & hvps_pkg::DRV_NEG);
    assign o_out.air_positive_closed    = |(r_drive & hvps_pkg::DRV_POS);
    assign o_out.precharge_relay_closed = |(r_drive & hvps_pkg::DRV_PRE);
    assign o_out.bus_voltage_q8         = r_out_volt;
    assign o_out.reboot_allowed         = (r_phase == hvps_pkg::PH_IDLE) ||
                                          (r_phase == hvps_pkg::PH_FAULT);

    // checks
    `HVPS_ASSERT_NOW(a_pos_needs_neg, |(r_drive & hvps_pkg::DRV_POS), |(r_drive & hvps_pkg::DRV_NEG), "positive contactor closed without negative")
    `HVPS_ASSERT_NOW(a_idle_open, r_phase == hvps_pkg::PH_IDLE, r_drive == '0, "contactor closed while idle")
    `HVPS_ASSERT_NEXT(a_timer_restart, w_s2_adv && (n_phase != r_phase), r_ticks == '0, "phase timer not restarted on phase change")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HV precharge sequencer testbench
// Drives tick items through the sequencer under several register settings
// and handshake idling patterns. A cycle-free model of the sequence predicts
// each result, and every accepted result is checked field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 80;
    localparam int DWELL_ITEMS  = 40;

    // local copies of the package widths
    localparam int MV_W       = hvps_pkg::MV_W;
    localparam int GAIN_W     = hvps_pkg::GAIN_W;
    localparam int VOLT_W     = hvps_pkg::VOLT_W;
    localparam int TICKS_W    = hvps_pkg::TICKS_W;
    localparam int RL_W       = hvps_pkg::RL_W;
    localparam int PHASE_W    = hvps_pkg::PHASE_W;
    localparam int DRV_W      = hvps_pkg::DRV_W;
    localparam int CFG_IDX_W  = hvps_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = hvps_pkg::CFG_DATA_W;

    // runlevels with no special meaning
    localparam logic [RL_W-1:0] RL_OTHER = 2'd2;
    localparam logic [RL_W-1:0] RL_SPARE = 2'd3;

    localparam logic [VOLT_W-1:0]  VOLT_MAX  = '1;
    localparam logic [MV_W-1:0]    MV_MAX    = '1;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;
    localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic            sup;
        logic [RL_W-1:0] rl;
    } t_tick;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               neg;
        logic               pos;
        logic               pre;
        logic [VOLT_W-1:0]  volts;
        logic               reboot;
    } t_status;

    logic i_clk;
    logic i_rst_n;

    hvps_in_if  tick_ch ();
    hvps_out_if status_ch ();
    hvps_cfg_if cfg_ch ();

    hv_precharge_sequencer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (status_ch),
        .i_cfg   (cfg_ch)
    );

    // shadow copy of the registers
    logic [MV_W-1:0]    reg_offset;
    logic [GAIN_W-1:0]  reg_gain;
    logic [VOLT_W-1:0]  reg_connect_thr;
    logic [VOLT_W-1:0]  reg_hv_thr;
    logic [TICKS_W-1:0] reg_drawdown;

    // shadow copy of the sequencer state
    logic [PHASE_W-1:0] seq_phase;
    logic [TICKS_W-1:0] seq_ticks;
    logic               seq_please_prev;
    logic [DRV_W-1:0]   seq_drive;

    t_tick   pending_ticks[$];
    t_status expected_status[$];
    int      items_queued    = 0;
    int      results_checked = 0;
    int      mismatches      = 0;
    int      idle_cycles     = 0;
    int      src_idle_pct;
    int      snk_stall_pct;
    logic    hold_req;
    logic    hold_ack;
    int      hold_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // one tick of the sequence: bus voltage, phase step, contactor drive
    task automatic step_sequencer(input t_tick t, output t_status s);
        logic               please;
        logic               no_hv;
        logic               hv;
        logic               drawn;
        logic [35:0]        prod;
        logic [VOLT_W-1:0]  volts;
        logic [PHASE_W-1:0] nxt;
        please = t.sup && (t.rl == hvps_pkg::RL_PLEASE_HV);
        no_hv  = t.sup && (t.rl == hvps_pkg::RL_NO_HV);
        prod   = 36'(t.mv - reg_offset) * 36'(reg_gain);
        if (t.mv <= reg_offset) begin
            volts = '0;
        end else if (prod[35:8] > 28'(VOLT_MAX)) begin
            volts = VOLT_MAX;
        end else begin
            volts = prod[27:8];
        end
        hv = volts >= reg_hv_thr;
        if (seq_ticks != TICKS_MAX) begin
            seq_ticks = seq_ticks + 1'b1;
        end
        drawn = !hv || (seq_ticks > reg_drawdown);
        nxt = seq_phase;
        case (seq_phase)
            hvps_pkg::PC_IDLE: begin
                if (please && !seq_please_prev) begin
                    seq_drive = seq_drive | hvps_pkg::DRV_NEG | hvps_pkg::DRV_PRE;
                    nxt = hvps_pkg::PC_PRECHARGING;
                end else begin
                    seq_drive = '0;
                end
            end
            hvps_pkg::PC_PRECHARGING: begin
                if (no_hv || !t.sup) begin
                    nxt = hvps_pkg::PC_DISCONNECTING;
                end else if (volts >= reg_connect_thr) begin
                    seq_drive = seq_drive | hvps_pkg::DRV_POS;
                    nxt = hvps_pkg::PC_CONNECTED;
                end
            end
            hvps_pkg::PC_CONNECTED: begin
                if (no_hv || !t.sup) begin
                    nxt = hvps_pkg::PC_DISCONNECTING;
                end
            end
            hvps_pkg::PC_DISCONNECTING: begin
                if (drawn) begin
                    seq_drive = '0;
                    nxt = hvps_pkg::PC_IDLE;
                end
            end
            hvps_pkg::PC_FAULT: begin
                if (drawn) begin
                    seq_drive = '0;
                end
            end
            default: begin
                nxt = hvps_pkg::PC_FAULT;
            end
        endcase
        if (nxt != seq_phase) begin
            seq_phase = nxt;
            seq_ticks = '0;
        end
        seq_please_prev = please;
        s.phase  = seq_phase;
        s.neg    = |(seq_drive & hvps_pkg::DRV_NEG);
        s.pos    = |(seq_drive & hvps_pkg::DRV_POS);
        s.pre    = |(seq_drive & hvps_pkg::DRV_PRE);
        s.volts  = volts;
        s.reboot = (seq_phase == hvps_pkg::PC_IDLE) || (seq_phase == hvps_pkg::PC_FAULT);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < MAX_REPORTS) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
            mismatches++;
        end
    endtask

    // tick driver, fed from the pending queue
    always @(posedge i_clk) begin : drive_ticks
        t_tick t;
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
        end else if (!tick_ch.valid || tick_ch.ready) begin
            if (pending_ticks.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                t = pending_ticks.pop_front();
                tick_ch.valid            <= 1'b1;
                tick_ch.calibrated_mv    <= t.mv;
                tick_ch.supervisor_ok    <= t.sup;
                tick_ch.runlevel_request <= t.rl;
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            status_ch.ready <= 1'b0;
            hold_ack        <= 1'b0;
            hold_left       <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack        <= hold_req;
            hold_left       <= HOLD_CYCLES;
            status_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            status_ch.ready <= 1'b0;
        end else begin
            status_ch.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
        end
    end

    // predict on accepted ticks, check accepted results
    always @(posedge i_clk) begin : score_results
        t_tick   t;
        t_status want;
        if (i_rst_n) begin
            if (tick_ch.valid && tick_ch.ready) begin
                t = '{mv: tick_ch.calibrated_mv, sup: tick_ch.supervisor_ok,
                      rl: tick_ch.runlevel_request};
                step_sequencer(t, want);
                expected_status.push_back(want);
            end
            if (status_ch.valid && status_ch.ready) begin
                results_checked++;
                if (expected_status.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: result item with nothing expected", $time);
                    end
                    mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("phase", 32'(want.phase), 32'(status_ch.phase));
                    check_field("air_negative_closed", 32'(want.neg),
                                32'(status_ch.air_negative_closed));
                    check_field("air_positive_closed", 32'(want.pos),
                                32'(status_ch.air_positive_closed));
                    check_field("precharge_relay_closed", 32'(want.pre),
                                32'(status_ch.precharge_relay_closed));
                    check_field("bus_voltage_q8", 32'(want.volts),
                                32'(status_ch.bus_voltage_q8));
                    check_field("reboot_allowed", 32'(want.reboot),
                                32'(status_ch.reboot_allowed));
                end
            end
        end
    end

    // watchdog: any accepted item on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready)
                || (status_ch.valid && status_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_tick(input logic [MV_W-1:0] mv, input logic sup,
                              input logic [RL_W-1:0] rl);
        pending_ticks.push_back('{mv: mv, sup: sup, rl: rl});
        items_queued++;
    endtask

    // one in ten session items is replaced by a fully random one
    task automatic queue_noisy(input logic [MV_W-1:0] mv, input logic sup,
                               input logic [RL_W-1:0] rl);
        if ($urandom_range(9, 0) == 0) begin
            queue_tick(MV_W'($urandom_range(4095, 0)), 1'($urandom_range(1, 0)),
                       RL_W'($urandom_range(3, 0)));
        end else begin
            queue_tick(mv, sup, rl);
        end
    endtask

    // reading in mV that lands within a few counts of a Q8 threshold
    function automatic logic [MV_W-1:0] mv_near(input logic [VOLT_W-1:0] thr);
        longint need;
        if (reg_gain == 0) begin
            return MV_W'($urandom_range(4095, 0));
        end
        need = longint'(reg_offset)
             + (longint'(thr) * 256 + longint'(reg_gain) - 1) / longint'(reg_gain)
             + int'($urandom_range(6, 0)) - 3;
        if (need < 0) begin
            need = 0;
        end
        if (need > longint'(MV_MAX)) begin
            need = longint'(MV_MAX);
        end
        return need[MV_W-1:0];
    endfunction

    function automatic logic [MV_W-1:0] pick_mv();
        case ($urandom_range(3, 0))
            0:       return MV_W'($urandom_range(4095, 0));
            1:       return mv_near(reg_connect_thr);
            2:       return mv_near(reg_hv_thr);
            default: return MV_W'($urandom_range(63, 0));
        endcase
    endfunction

    function automatic logic [RL_W-1:0] rl_except(input logic [RL_W-1:0] skip);
        logic [RL_W-1:0] rl;
        do rl = RL_W'($urandom_range(3, 0)); while (rl == skip);
        return rl;
    endfunction

    // a full connect cycle: request edge, precharge, run, drop, drawdown
    task automatic queue_session();
        repeat ($urandom_range(2, 1)) begin
            queue_noisy(pick_mv(), 1'($urandom_range(1, 0)),
                        rl_except(hvps_pkg::RL_PLEASE_HV));
        end
        queue_noisy(pick_mv(), 1'b1, hvps_pkg::RL_PLEASE_HV);
        repeat ($urandom_range(10, 0)) begin
            queue_noisy(pick_mv(), 1'b1, rl_except(hvps_pkg::RL_NO_HV));
        end
        if ($urandom_range(1, 0) == 1) begin
            queue_noisy(pick_mv(), 1'b1, hvps_pkg::RL_NO_HV);
        end else begin
            queue_noisy(pick_mv(), 1'b0, RL_W'($urandom_range(3, 0)));
        end
        repeat ($urandom_range(14, 1)) begin
            queue_noisy(pick_mv(), 1'($urandom_range(1, 0)), RL_W'($urandom_range(3, 0)));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        case (idx)
            hvps_pkg::CFG_ADC_OFFSET:  reg_offset      = value[MV_W-1:0];
            hvps_pkg::CFG_GAIN:        reg_gain        = value[GAIN_W-1:0];
            hvps_pkg::CFG_CONNECT_THR: reg_connect_thr = value[VOLT_W-1:0];
            hvps_pkg::CFG_HV_THR:      reg_hv_thr      = value[VOLT_W-1:0];
            hvps_pkg::CFG_DRAWDOWN:    reg_drawdown    = value[TICKS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [MV_W-1:0] offset,
                                  input logic [GAIN_W-1:0] gain,
                                  input logic [VOLT_W-1:0] connect_thr,
                                  input logic [VOLT_W-1:0] hv_thr,
                                  input logic [TICKS_W-1:0] drawdown);
        write_reg(hvps_pkg::CFG_ADC_OFFSET, CFG_DATA_W'(offset));
        write_reg(hvps_pkg::CFG_GAIN, CFG_DATA_W'(gain));
        write_reg(hvps_pkg::CFG_CONNECT_THR, CFG_DATA_W'(connect_thr));
        write_reg(hvps_pkg::CFG_HV_THR, CFG_DATA_W'(hv_thr));
        write_reg(hvps_pkg::CFG_DRAWDOWN, CFG_DATA_W'(drawdown));
    endtask

    // sender holds until every expected result is back
    task automatic wait_drained();
        while (results_checked != items_queued) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        @(posedge i_clk);
        src_idle_pct  <= src_pct;
        snk_stall_pct <= snk_pct;
    endtask

    // stimulus
    initial begin : stimulus
        int src_modes[4];
        int snk_modes[4];
        int start_count;
        logic [GAIN_W-1:0] gain;
        src_modes = '{0, 87, 0, 27};
        snk_modes = '{0, 0, 87, 27};

        i_rst_n                  = 1'b0;
        tick_ch.valid            = 1'b0;
        tick_ch.calibrated_mv    = '0;
        tick_ch.supervisor_ok    = 1'b0;
        tick_ch.runlevel_request = hvps_pkg::RL_NO_HV;
        status_ch.ready          = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = hvps_pkg::CFG_ADC_OFFSET;
        cfg_ch.data              = '0;
        hold_req                 = 1'b0;
        src_idle_pct             = 0;
        snk_stall_pct            = 0;
        reg_offset               = hvps_pkg::RST_ADC_OFFSET;
        reg_gain                 = hvps_pkg::RST_GAIN;
        reg_connect_thr          = hvps_pkg::RST_CONNECT_THR;
        reg_hv_thr               = hvps_pkg::RST_HV_THR;
        reg_drawdown             = hvps_pkg::RST_DRAWDOWN;
        seq_phase                = hvps_pkg::PC_IDLE;
        seq_ticks                = '0;
        seq_please_prev          = 1'b0;
        seq_drive                = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: unity gain, 32 V connect, 60 V HV
        queue_tick(12'd0, 1'b1, RL_OTHER);
        queue_tick(12'd0, 1'b0, hvps_pkg::RL_PLEASE_HV);  // please without supervisor
        queue_tick(MV_MAX, 1'b1, hvps_pkg::RL_PLEASE_HV); // edge: start precharge
        queue_tick(12'd10, 1'b1, hvps_pkg::RL_PLEASE_HV); // below connect threshold
        queue_tick(12'd32, 1'b1, RL_SPARE);               // exactly at threshold
        queue_tick(MV_MAX, 1'b1, RL_OTHER);
        queue_tick(12'd100, 1'b1, hvps_pkg::RL_NO_HV);    // no-HV request
        queue_tick(12'd60, 1'b1, hvps_pkg::RL_PLEASE_HV); // HV exactly present
        queue_tick(12'd59, 1'b1, hvps_pkg::RL_PLEASE_HV); // HV gone: open
        queue_tick(12'd0, 1'b1, hvps_pkg::RL_PLEASE_HV);  // held request, no edge
        queue_tick(12'd0, 1'b1, RL_OTHER);
        queue_tick(12'd0, 1'b1, hvps_pkg::RL_PLEASE_HV);
        queue_tick(MV_MAX, 1'b0, hvps_pkg::RL_PLEASE_HV); // supervisor lost in precharge
        queue_tick(MV_MAX, 1'b0, hvps_pkg::RL_NO_HV);
        queue_tick(12'd0, 1'b0, hvps_pkg::RL_NO_HV);
        queue_tick(12'd0, 1'b1, hvps_pkg::RL_PLEASE_HV);
        queue_tick(12'd0, 1'b1, hvps_pkg::RL_NO_HV);      // no-HV in precharge
        queue_tick(12'd0, 1'b0, RL_SPARE);
        queue_tick(MV_MAX, 1'b1, hvps_pkg::RL_PLEASE_HV);
        queue_tick(MV_MAX, 1'b1, hvps_pkg::RL_PLEASE_HV);
        queue_tick(MV_MAX, 1'b0, RL_OTHER);               // supervisor lost while connected
        queue_tick(12'd0, 1'b1, RL_OTHER);
        wait_drained();

        // full offset, zero gain, zero HV threshold, no drawdown wait
        write_all_regs(MV_MAX, '0, VOLT_MAX, '0, '0);
        queue_tick(MV_MAX, 1'b1, hvps_pkg::RL_PLEASE_HV);
        queue_tick(MV_MAX, 1'b1, RL_OTHER);
        queue_tick(12'd0, 1'b1, hvps_pkg::RL_NO_HV);
        queue_tick(12'd0, 1'b1, RL_OTHER);
        wait_drained();

        // full gain saturates; drawdown runs out on the timer
        write_all_regs('0, GAIN_MAX, '0, VOLT_MAX, 16'd3);
        queue_tick(MV_MAX, 1'b1, hvps_pkg::RL_PLEASE_HV);
        queue_tick(12'd1, 1'b1, RL_OTHER);
        queue_tick(MV_MAX, 1'b1, hvps_pkg::RL_NO_HV);
        repeat (4) queue_tick(MV_MAX, 1'b1, hvps_pkg::RL_NO_HV);
        wait_drained();

        // longest drawdown: contactors stay closed while HV remains
        write_all_regs('0, GAIN_MAX, '0, VOLT_MAX, TICKS_MAX);
        queue_tick(MV_MAX, 1'b1, hvps_pkg::RL_PLEASE_HV);
        queue_tick(MV_MAX, 1'b1, hvps_pkg::RL_PLEASE_HV);
        queue_tick(MV_MAX, 1'b1, hvps_pkg::RL_NO_HV);
        repeat (DWELL_ITEMS) begin
            queue_tick(MV_MAX, 1'($urandom_range(1, 0)), RL_W'($urandom_range(3, 0)));
        end
        queue_tick(12'd0, 1'b1, RL_OTHER);
        wait_drained();

        // random sessions under random registers, one idling pattern each
        for (int m = 0; m < 4; m++) begin
            wait_drained();
            case ($urandom_range(2, 0))
                0:       gain = GAIN_W'($urandom_range(24'h3FFFF, 24'h4000));
                1:       gain = GAIN_W'($urandom_range(24'hFFFFFF, 0));
                default: gain = hvps_pkg::RST_GAIN;
            endcase
            write_all_regs(MV_W'($urandom_range(300, 0)), gain,
                           VOLT_W'($urandom_range(20'h40000, 0)),
                           VOLT_W'($urandom_range(20'h40000, 0)),
                           TICKS_W'($urandom_range(12, 0)));
            set_idling(src_modes[m], snk_modes[m]);
            start_count = items_queued;
            while (items_queued - start_count < PHASE_ITEMS) queue_session();
            if (m == 0) begin
                // long receiver hold-off while ticks keep coming
                @(posedge i_clk);
                hold_req <= ~hold_req;
            end
        end

        wait_drained();
        if (expected_status.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_status.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
